// ----- sv/bmh_pkg.sv -----
// Package for the binary max-heap queue: widths, codes, payload and entry types.
`timescale 1ns / 1ps
`default_nettype none
package bmh_pkg;

    localparam int KEY_BITS       = 32;
    localparam int TAG_BITS       = 16;
    localparam int COUNT_BITS     = 9;
    localparam int HEAP_DEPTH_DEF = 256;

    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_UP_CMP,
        ST_UP_FIN,
        ST_LAST_RD,
        ST_DOWN_CMP,
        ST_DONE
    } state_t;

    typedef struct packed
    {
        logic [KEY_BITS-1:0] key;
        logic [TAG_BITS-1:0] tag;
    } entry_t;

    typedef struct packed
    {
        op_t                 opcode;
        logic [KEY_BITS-1:0] entry_key;
        logic [TAG_BITS-1:0] entry_tag;
    } cmd_t;

    typedef struct packed
    {
        status_t               status;
        logic [KEY_BITS-1:0]   removed_key;
        logic [TAG_BITS-1:0]   removed_tag;
        logic [KEY_BITS-1:0]   top_key;
        logic [TAG_BITS-1:0]   top_tag;
        logic [COUNT_BITS-1:0] entry_count;
    } res_t;

endpackage
`default_nettype wire

// ----- sv/bmh_mem.sv -----
// Heap entry store: one write port, two registered read ports.
`timescale 1ns / 1ps
`default_nettype none
module bmh_mem #(
    parameter int HEAP_DEPTH = bmh_pkg::HEAP_DEPTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          wr_en,
    input  wire logic [$clog2(HEAP_DEPTH)-1:0] wr_addr,
    input  wire bmh_pkg::entry_t               wr_data,
    input  wire logic [$clog2(HEAP_DEPTH)-1:0] rd_addr_a,
    input  wire logic [$clog2(HEAP_DEPTH)-1:0] rd_addr_b,
    output bmh_pkg::entry_t                    rd_data_a,
    output bmh_pkg::entry_t                    rd_data_b
);

    bmh_pkg::entry_t mem [HEAP_DEPTH];

    // Write one entry per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Register both read ports
    always_ff @(posedge clk)
    begin
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule
`default_nettype wire

// ----- sv/bmh_ctrl.sv -----
// Heap sequencer: sift-up and sift-down over a shared key compare, plus result register.
`timescale 1ns / 1ps
`default_nettype none
module bmh_ctrl #(
    parameter int HEAP_DEPTH = bmh_pkg::HEAP_DEPTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cmd_valid,
    output logic                               cmd_stall,
    input  wire bmh_pkg::cmd_t                 cmd,
    output logic                               res_valid,
    input  wire logic                          res_stall,
    output bmh_pkg::res_t                      res,
    output logic                               wr_en,
    output logic [$clog2(HEAP_DEPTH)-1:0]      wr_addr,
    output bmh_pkg::entry_t                    wr_data,
    output logic [$clog2(HEAP_DEPTH)-1:0]      rd_addr_a,
    output logic [$clog2(HEAP_DEPTH)-1:0]      rd_addr_b,
    input  wire bmh_pkg::entry_t               rd_data_a,
    input  wire bmh_pkg::entry_t               rd_data_b
);

    localparam int IDX_W = $clog2(HEAP_DEPTH);
    localparam int CNT_W = $clog2(HEAP_DEPTH + 1);
    localparam int EXT_W = IDX_W + 2;

    bmh_pkg::state_t  state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    bmh_pkg::entry_t  moving_reg, moving_next;
    bmh_pkg::entry_t  removed_reg, removed_next;
    bmh_pkg::status_t status_reg, status_next;
    bmh_pkg::entry_t  root_reg;
    logic             res_valid_reg, res_valid_next;
    bmh_pkg::res_t    res_reg, res_next;

    logic [IDX_W-1:0] occ_idx;
    logic [IDX_W-1:0] par_idx;
    logic [EXT_W-1:0] lc_ext;
    logic [EXT_W-1:0] rc_ext;
    logic [EXT_W-1:0] cnt_ext;
    logic             le_left;
    logic             le_right;
    logic             left_le_right;
    logic             lt_parent;
    logic [IDX_W-1:0] pick_idx;
    bmh_pkg::entry_t  pick_entry;

    function automatic logic [IDX_W-1:0] parent_of(input logic [IDX_W-1:0] p);
        logic [IDX_W-1:0] pm1;
        pm1 = p - 1'b1;
        return IDX_W'(pm1 >> 1);
    endfunction

    function automatic logic [EXT_W-1:0] left_of(input logic [IDX_W-1:0] p);
        return {1'b0, p, 1'b1};
    endfunction

    // Index arithmetic around the current position
    assign occ_idx = count_reg[IDX_W-1:0];
    assign par_idx = parent_of(pos_reg);
    assign lc_ext  = left_of(pos_reg);
    assign rc_ext  = lc_ext + 1'b1;
    assign cnt_ext = EXT_W'(count_reg);

    // Shared key compare unit
    assign le_left       = moving_reg.key <= rd_data_a.key;
    assign le_right      = moving_reg.key <= rd_data_b.key;
    assign left_le_right = rd_data_a.key <= rd_data_b.key;
    assign lt_parent     = moving_reg.key < rd_data_a.key;

    // Pick the larger child, right wins a tie
    always_comb
    begin
        if (rc_ext < cnt_ext && left_le_right)
        begin
            pick_idx   = rc_ext[IDX_W-1:0];
            pick_entry = rd_data_b;
        end
        else
        begin
            pick_idx   = lc_ext[IDX_W-1:0];
            pick_entry = rd_data_a;
        end
    end

    // Sequence the heap operation
    always_comb
    begin
        logic [EXT_W-1:0] next_lc;
        next_lc        = '0;
        state_next     = state_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        moving_next    = moving_reg;
        removed_next   = removed_reg;
        status_next    = status_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        wr_en          = 1'b0;
        wr_addr        = pos_reg;
        wr_data        = moving_reg;
        rd_addr_a      = '0;
        rd_addr_b      = '0;

        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            bmh_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    removed_next = '0;
                    status_next  = bmh_pkg::STATUS_OK;
                    if (cmd.opcode == bmh_pkg::OP_INSERT)
                    begin
                        if (count_reg == CNT_W'(HEAP_DEPTH))
                        begin
                            status_next = bmh_pkg::STATUS_FULL;
                            state_next  = bmh_pkg::ST_DONE;
                        end
                        else
                        begin
                            moving_next = '{key: cmd.entry_key, tag: cmd.entry_tag};
                            pos_next    = occ_idx;
                            count_next  = count_reg + 1'b1;
                            if (count_reg == '0)
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = '0;
                                wr_data    = '{key: cmd.entry_key, tag: cmd.entry_tag};
                                state_next = bmh_pkg::ST_DONE;
                            end
                            else
                            begin
                                rd_addr_a  = parent_of(occ_idx);
                                state_next = bmh_pkg::ST_UP_CMP;
                            end
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = bmh_pkg::STATUS_EMPTY;
                            state_next  = bmh_pkg::ST_DONE;
                        end
                        else
                        begin
                            removed_next = root_reg;
                            count_next   = count_reg - 1'b1;
                            rd_addr_a    = IDX_W'(count_reg - 1'b1);
                            state_next   = bmh_pkg::ST_LAST_RD;
                        end
                    end
                end
            end

            bmh_pkg::ST_UP_CMP:
            begin
                wr_en = 1'b1;
                if (lt_parent)
                begin
                    state_next = bmh_pkg::ST_DONE;
                end
                else
                begin
                    wr_data  = rd_data_a;
                    pos_next = par_idx;
                    if (par_idx == '0)
                    begin
                        state_next = bmh_pkg::ST_UP_FIN;
                    end
                    else
                    begin
                        rd_addr_a = parent_of(par_idx);
                    end
                end
            end

            bmh_pkg::ST_UP_FIN:
            begin
                wr_en      = 1'b1;
                state_next = bmh_pkg::ST_DONE;
            end

            bmh_pkg::ST_LAST_RD:
            begin
                moving_next = rd_data_a;
                pos_next    = '0;
                next_lc     = left_of('0);
                rd_addr_a   = next_lc[IDX_W-1:0];
                rd_addr_b   = IDX_W'(next_lc + 1'b1);
                if (count_reg == '0)
                begin
                    state_next = bmh_pkg::ST_DONE;
                end
                else
                begin
                    state_next = bmh_pkg::ST_DOWN_CMP;
                end
            end

            bmh_pkg::ST_DOWN_CMP:
            begin
                wr_en = 1'b1;
                if (lc_ext < cnt_ext &&
                    (le_left || (rc_ext < cnt_ext && le_right)))
                begin
                    wr_data   = pick_entry;
                    pos_next  = pick_idx;
                    next_lc   = left_of(pick_idx);
                    rd_addr_a = next_lc[IDX_W-1:0];
                    rd_addr_b = IDX_W'(next_lc + 1'b1);
                end
                else
                begin
                    state_next = bmh_pkg::ST_DONE;
                end
            end

            bmh_pkg::ST_DONE:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next       = 1'b1;
                    res_next.status      = status_reg;
                    res_next.removed_key = removed_reg.key;
                    res_next.removed_tag = removed_reg.tag;
                    res_next.top_key     = (count_reg != '0) ? root_reg.key : '0;
                    res_next.top_tag     = (count_reg != '0) ? root_reg.tag : '0;
                    res_next.entry_count = bmh_pkg::COUNT_BITS'(count_reg);
                    state_next           = bmh_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = bmh_pkg::ST_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bmh_pkg::ST_IDLE;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Advance payload registers, shadow the root entry on every root write
    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        moving_reg  <= moving_next;
        removed_reg <= removed_next;
        status_reg  <= status_next;
        res_reg     <= res_next;
        if (wr_en && wr_addr == '0)
        begin
            root_reg <= wr_data;
        end
    end

    assign cmd_stall = (state_reg != bmh_pkg::ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule
`default_nettype wire

// ----- sv/binary_max_heap_queue.sv -----
// Binary max-heap priority queue: top level joining the sequencer and the entry store.
// Usage:
//   cmd channel (cmd_valid, cmd_stall, cmd) carries one operation per transaction:
//   insert of a key and tag, or removal of the maximum entry. res channel
//   (res_valid, res_stall, res) returns one result per operation: status,
//   removed entry, root entry after the operation and the entry count.
//   A transaction moves on a rising edge with valid high and stall low.
// Throughput:
//   One operation at a time; cmd_stall is high from acceptance until the
//   result is loaded. Insert and removal visit one heap level per step: the
//   sift loop reads children or the parent from the two-port entry store,
//   compares in the shared key compare and writes back one entry per cycle.
//   Full inserts and empty removals go straight to the result.
// Reset:
//   rst_n clears the count, the sequencer and the result valid; the store is
//   not cleared, and only entries below the count are ever used.
// Stall:
//   A result waits in the output register while res_stall is high; the next
//   operation is still accepted and runs, then waits to load until it frees.
`timescale 1ns / 1ps
`default_nettype none
module binary_max_heap_queue #(
    parameter int HEAP_DEPTH = bmh_pkg::HEAP_DEPTH_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    output logic               cmd_stall,
    input  wire bmh_pkg::cmd_t cmd,
    output logic               res_valid,
    input  wire logic          res_stall,
    output bmh_pkg::res_t      res
);

    localparam int IDX_W = $clog2(HEAP_DEPTH);

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    bmh_pkg::entry_t  wr_data;
    logic [IDX_W-1:0] rd_addr_a;
    logic [IDX_W-1:0] rd_addr_b;
    bmh_pkg::entry_t  rd_data_a;
    bmh_pkg::entry_t  rd_data_b;

    // Sequence operations
    bmh_ctrl #(
        .HEAP_DEPTH (HEAP_DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    // Hold heap entries
    bmh_mem #(
        .HEAP_DEPTH (HEAP_DEPTH)
    ) u_mem (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

endmodule
`default_nettype wire
